// ===== rtl/mgma_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mgma_pkg
// Shared types and address constants of the gated memory access unit.
// ---------------------------------------------------------------------------
package mgma_pkg;

  // Access kinds carried on the input tuser
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_LOAD  = 2'd2
  } kind_t;

  // Source of the read byte in the result stage
  typedef enum logic [2:0] {
    RD_ZERO = 3'd0,
    RD_MEM  = 3'd1,
    RD_BOOT = 3'd2,
    RD_FF   = 3'd3,
    RD_BOFF = 3'd4
  } rd_sel_t;

  // Decode result for one item
  typedef struct packed {
    logic    mem_we;
    logic    boot_we;
    logic    done;
    rd_sel_t rd_sel;
  } gate_t;

  localparam logic [15:0] ADDR_LCDC     = 16'hFF40;
  localparam logic [15:0] ADDR_STAT     = 16'hFF41;
  localparam logic [15:0] ADDR_BOOT_OFF = 16'hFF50;
  localparam logic [15:0] ADDR_IE       = 16'hFFFF;
  localparam logic [15:0] HRAM_LO       = 16'hFF80;
  localparam logic [15:0] HRAM_HI       = 16'hFFFE;
  localparam logic [15:0] WRAM_LO       = 16'hC000;
  localparam logic [15:0] WRAM_HI       = 16'hDFFF;
  localparam logic [15:0] IO_LO         = 16'hFF00;
  localparam logic [15:0] IO_HI         = 16'hFF7E;
  localparam logic [15:0] VRAM_LO       = 16'h8000;
  localparam logic [15:0] VRAM_HI       = 16'h9FFF;
  localparam logic [15:0] OAM_LO        = 16'hFE00;
  localparam logic [15:0] OAM_HI        = 16'hFE9F;

  localparam logic [7:0]  BYTE_FF       = 8'hFF;
  localparam logic [1:0]  MODE_XFER     = 2'd3;
  localparam int          LCD_ON_BIT    = 7;

endpackage

// ===== rtl/mode_gated_memory_access_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mode_gated_memory_access_unit
// 64 KiB bus memory with boot ROM overlay and DMA / video mode write gating.
// ---------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_tvalid/s_tready: s_tuser carries the access kind
//   (read, write, boot ROM load), s_tdata the address, data and the force and
//   DMA flags. Each item yields exactly one result item on m_tvalid/m_tready
//   with the read byte and a write-done flag.
//   The item is decoded and the memories are accessed at the accepting edge,
//   and the result is shown from the next cycle on, taken straight from the
//   registered RAM read ports.
//   Throughput is one item per cycle unless stalled; the single port of the
//   main RAM serves at most one access per item and writes land at the
//   accepting edge, so a following read of the same byte sees the new value.
//   The LCD control, STAT mode and boot-disable bytes are mirrored in
//   registers so write gating needs no extra RAM read.
//   Reset clears the result stage and the boot-disable byte (boot ROM visible);
//   the RAM contents are not cleared.
//   While the receiver stalls, the result holds and s_tready stays low, so no
//   RAM access can disturb the held read data.
// ---------------------------------------------------------------------------
module mode_gated_memory_access_unit #(
  parameter int BOOT_ROM_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // address[15:0], write_data[23:16], force_req[24],
                                 // dma_active[25], zero fill [31:26]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // read_data[7:0], write_done[8], zero fill [15:9]
);

  localparam int BOOT_AW = (BOOT_ROM_BYTES > 1) ? $clog2(BOOT_ROM_BYTES) : 1;

  logic [15:0]       address;
  logic [7:0]        write_data;
  logic              force_req, dma_active, accept;
  mgma_pkg::kind_t   kind;
  mgma_pkg::gate_t   gate;

  // mirrored control bytes
  logic [7:0]        boot_off;
  logic              lcd_on;
  logic [1:0]        stat_mode;

  // result stage
  logic              res_valid;
  logic              res_done;
  mgma_pkg::rd_sel_t res_sel;
  logic [7:0]        res_boff;
  logic [7:0]        mem_rdata, boot_rdata;
  logic [7:0]        read_byte;

  assign address    = s_tdata[15:0];
  assign write_data = s_tdata[23:16];
  assign force_req  = s_tdata[24];
  assign dma_active = s_tdata[25];
  assign kind       = mgma_pkg::kind_t'(s_tuser);

  assign s_tready = !res_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  mgma_gate #(
    .BOOT_ROM_BYTES(BOOT_ROM_BYTES)
  ) u_gate (
    .kind      (kind),
    .address   (address),
    .force_req (force_req),
    .dma_active(dma_active),
    .lcd_on    (lcd_on),
    .stat_mode (stat_mode),
    .boot_off  (boot_off != 8'd0),
    .gate      (gate)
  );

  // main memory
  mgma_ram #(
    .DEPTH (65536),
    .ADDR_W(16),
    .DATA_W(8)
  ) u_main (
    .clk  (clk),
    .we   (accept && gate.mem_we),
    .re   (accept && gate.rd_sel == mgma_pkg::RD_MEM),
    .addr (address),
    .wdata(write_data),
    .rdata(mem_rdata)
  );

  // boot ROM
  mgma_ram #(
    .DEPTH (BOOT_ROM_BYTES),
    .ADDR_W(BOOT_AW),
    .DATA_W(8)
  ) u_boot (
    .clk  (clk),
    .we   (accept && gate.boot_we),
    .re   (accept && gate.rd_sel == mgma_pkg::RD_BOOT),
    .addr (address[BOOT_AW-1:0]),
    .wdata(write_data),
    .rdata(boot_rdata)
  );

  // control byte mirrors
  always_ff @(posedge clk) begin
    if (rst) begin
      boot_off <= 8'd0;
    end else if (accept && gate.mem_we && address == mgma_pkg::ADDR_BOOT_OFF) begin
      boot_off <= write_data;
    end
    if (accept && gate.mem_we && address == mgma_pkg::ADDR_LCDC) begin
      lcd_on <= write_data[mgma_pkg::LCD_ON_BIT];
    end
    if (accept && gate.mem_we && address == mgma_pkg::ADDR_STAT) begin
      stat_mode <= write_data[1:0];
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s_tready) begin
      res_valid <= s_tvalid;
    end
    if (accept) begin
      res_done <= gate.done;
      res_sel  <= gate.rd_sel;
      res_boff <= boot_off;
    end
  end

  // read byte select
  always_comb begin
    case (res_sel)
      mgma_pkg::RD_MEM:  read_byte = mem_rdata;
      mgma_pkg::RD_BOOT: read_byte = boot_rdata;
      mgma_pkg::RD_FF:   read_byte = mgma_pkg::BYTE_FF;
      mgma_pkg::RD_BOFF: read_byte = res_boff;
      default:           read_byte = 8'd0;
    endcase
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {7'd0, res_done, read_byte};

`ifndef SYNTH
  // boot ROM is visible right after reset
  a_boot_on_after_rst: assert property (@(posedge clk)
    $past(rst) |-> boot_off == 8'd0)
    else $error("boot-disable byte not cleared by reset");

  // a read never reports a stored write
  a_read_no_done: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == mgma_pkg::KIND_READ) |=> (m_tvalid && !m_tdata[8]))
    else $error("read reported write_done");

  // forced writes always land
  a_forced_write: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == mgma_pkg::KIND_WRITE && force_req) |=> (m_tvalid && m_tdata[8]))
    else $error("forced write dropped");

  // writes and loads return a zero byte
  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == mgma_pkg::KIND_WRITE || kind == mgma_pkg::KIND_LOAD))
      |=> m_tdata[7:0] == 8'd0)
    else $error("nonzero read byte on a write or load");

  // a held result blocks new items
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("item accepted while result stalled");
`endif

endmodule

// ===== rtl/mgma_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mgma_ram
// Single-port synchronous RAM with registered read data.
// ---------------------------------------------------------------------------
module mgma_ram #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/mgma_gate.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mgma_gate
// Access decode: write gating by DMA and video mode, read source selection.
// ---------------------------------------------------------------------------
module mgma_gate #(
  parameter int BOOT_ROM_BYTES = 256
) (
  input  mgma_pkg::kind_t kind,
  input  logic [15:0]     address,
  input  logic            force_req,
  input  logic            dma_active,
  input  logic            lcd_on,
  input  logic [1:0]      stat_mode,
  input  logic            boot_off,
  output mgma_pkg::gate_t gate
);

  localparam logic [16:0] BOOT_LIMIT = 17'(BOOT_ROM_BYTES);

  logic in_hram, in_wram, in_io, in_vram, in_oam, is_ie;
  logic boot_hit, load_hit, wr_ok;

  // address ranges
  always_comb begin
    in_hram  = address >= mgma_pkg::HRAM_LO && address <= mgma_pkg::HRAM_HI;
    in_wram  = address >= mgma_pkg::WRAM_LO && address <= mgma_pkg::WRAM_HI;
    in_io    = address >= mgma_pkg::IO_LO   && address <= mgma_pkg::IO_HI;
    in_vram  = address >= mgma_pkg::VRAM_LO && address <= mgma_pkg::VRAM_HI;
    in_oam   = address >= mgma_pkg::OAM_LO  && address <= mgma_pkg::OAM_HI;
    is_ie    = address == mgma_pkg::ADDR_IE;
    boot_hit = !boot_off && ({1'b0, address} < BOOT_LIMIT);
    load_hit = {9'b0, address[7:0]} < BOOT_LIMIT;
  end

  // write permission
  always_comb begin
    if (force_req) begin
      wr_ok = 1'b1;
    end else if (dma_active) begin
      wr_ok = in_hram;
    end else if (in_wram || in_hram || in_io || is_ie) begin
      wr_ok = 1'b1;
    end else if (in_vram) begin
      wr_ok = stat_mode != mgma_pkg::MODE_XFER || !lcd_on;
    end else if (in_oam) begin
      wr_ok = !stat_mode[1] || !lcd_on;
    end else begin
      wr_ok = 1'b0;
    end
  end

  // per-kind decode
  always_comb begin
    gate = '{mem_we: 1'b0, boot_we: 1'b0, done: 1'b0, rd_sel: mgma_pkg::RD_ZERO};
    unique case (kind)
      mgma_pkg::KIND_READ: begin
        if (!force_req && dma_active) begin
          gate.rd_sel = in_hram ? mgma_pkg::RD_MEM : mgma_pkg::RD_FF;
        end else if (boot_hit) begin
          gate.rd_sel = mgma_pkg::RD_BOOT;
        end else if (address == mgma_pkg::ADDR_BOOT_OFF) begin
          gate.rd_sel = mgma_pkg::RD_BOFF;
        end else begin
          gate.rd_sel = mgma_pkg::RD_MEM;
        end
      end
      mgma_pkg::KIND_WRITE: begin
        gate.mem_we = wr_ok;
        gate.done   = wr_ok;
      end
      mgma_pkg::KIND_LOAD: begin
        gate.boot_we = load_hit;
        gate.done    = load_hit;
      end
      default: begin
        gate.rd_sel = mgma_pkg::RD_ZERO;
      end
    endcase
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Stream-level test of the gated memory access unit.
// A short table of directed accesses covers the region bounds, video mode
// and LCD gating, DMA blanking and the boot ROM overlay. A long random run
// follows, checked against a behavioral memory image. Both stream sides
// idle at random, and every result is compared field by field in order.
// ---------------------------------------------------------------------------
module testbench;

  localparam int BOOT_BYTES = 256;
  localparam int RANDOM_ITEMS = 1025;

  // One bus access and its result
  typedef struct packed {
    mgma_pkg::kind_t kind;
    logic [15:0]     addr;
    logic [7:0]      wdata;
    logic            force_req;
    logic            dma;
  } access_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       write_done;
  } result_t;

  typedef struct packed {
    access_t acc;
    logic    typed;
    result_t res;
  } row_t;

  // Region bounds used for boundary addresses
  localparam logic [21:0][15:0] ADDR_BOUNDS = {
    16'h0000, 16'h00FF, 16'h0100, 16'h7FFF, 16'h8000, 16'h9FFF,
    16'hA000, 16'hBFFF, 16'hC000, 16'hDFFF, 16'hE000, 16'hFDFF,
    16'hFE00, 16'hFE9F, 16'hFEA0, 16'hFEFF, 16'hFF00, 16'hFF7E,
    16'hFF7F, 16'hFF80, 16'hFFFE, 16'hFFFF
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // address[15:0], write_data[23:16], force_req[24],
                               // dma_active[25], zero fill [31:26]
  logic [1:0]  s_tuser = '0;   // kind[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // read_data[7:0], write_done[8], zero fill [15:9]

  // Memory image of the block and what has been written so far
  logic [7:0]  mem_img [0:65535];
  bit          mem_valid [0:65535];
  logic [7:0]  boot_img [0:255];
  bit          boot_valid [0:255];
  logic [15:0] written_addrs [$];

  result_t     pending_results [$];
  row_t        directed_rows [$];

  int error_count = 0;
  int tx_idle_pct = 13;
  int rx_stall_pct = 13;
  int n_reads = 0, n_writes = 0, n_loads = 0, n_stored = 0;
  int n_boot_reads = 0, n_dma_blank = 0, n_results = 0;

  mode_gated_memory_access_unit #(.BOOT_ROM_BYTES(BOOT_BYTES)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  // Run limit
  initial begin
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic bit in_span(input logic [15:0] a, input logic [15:0] lo,
                                 input logic [15:0] hi);
    return a >= lo && a <= hi;
  endfunction

  // Expected result of one access; updates the memory image
  function automatic result_t bus_result(input access_t a);
    result_t     r;
    logic [1:0]  mode;
    logic        lcd_on;
    logic        ok;
    r = '0;
    case (a.kind)
      mgma_pkg::KIND_READ: begin
        n_reads++;
        if (!a.force_req && a.dma) begin
          // DMA blanks everything but high RAM
          if (in_span(a.addr, mgma_pkg::HRAM_LO, mgma_pkg::HRAM_HI)) begin
            r.read_data = mem_img[a.addr];
          end else begin
            r.read_data = mgma_pkg::BYTE_FF;
            n_dma_blank++;
          end
        end else if (mem_img[mgma_pkg::ADDR_BOOT_OFF] == 8'h00 && a.addr < BOOT_BYTES) begin
          r.read_data = boot_img[a.addr[7:0]];
          n_boot_reads++;
        end else begin
          r.read_data = mem_img[a.addr];
        end
      end
      mgma_pkg::KIND_WRITE: begin
        n_writes++;
        mode   = mem_img[mgma_pkg::ADDR_STAT][1:0];
        lcd_on = mem_img[mgma_pkg::ADDR_LCDC][mgma_pkg::LCD_ON_BIT];
        if (a.force_req)
          ok = 1'b1;
        else if (a.dma)
          ok = in_span(a.addr, mgma_pkg::HRAM_LO, mgma_pkg::HRAM_HI);
        else if (in_span(a.addr, mgma_pkg::WRAM_LO, mgma_pkg::WRAM_HI) ||
                 in_span(a.addr, mgma_pkg::HRAM_LO, mgma_pkg::HRAM_HI) ||
                 in_span(a.addr, mgma_pkg::IO_LO, mgma_pkg::IO_HI))
          ok = 1'b1;
        else if (in_span(a.addr, mgma_pkg::VRAM_LO, mgma_pkg::VRAM_HI))
          ok = mode != mgma_pkg::MODE_XFER || !lcd_on;
        else if (in_span(a.addr, mgma_pkg::OAM_LO, mgma_pkg::OAM_HI))
          ok = mode < 2'd2 || !lcd_on;
        else
          ok = a.addr == mgma_pkg::ADDR_IE;
        if (ok) begin
          mem_img[a.addr] = a.wdata;
          if (!mem_valid[a.addr]) begin
            mem_valid[a.addr] = 1'b1;
            written_addrs.push_back(a.addr);
          end
          r.write_done = 1'b1;
          n_stored++;
        end
      end
      mgma_pkg::KIND_LOAD: begin
        n_loads++;
        if (a.addr[7:0] < BOOT_BYTES) begin
          boot_img[a.addr[7:0]]   = a.wdata;
          boot_valid[a.addr[7:0]] = 1'b1;
          r.write_done = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // True when the access reads, or its write gate depends on, a byte never written
  function automatic bit touches_unwritten(input access_t a);
    if (a.kind == mgma_pkg::KIND_READ) begin
      if (!a.force_req && a.dma)
        return in_span(a.addr, mgma_pkg::HRAM_LO, mgma_pkg::HRAM_HI) && !mem_valid[a.addr];
      if (mem_img[mgma_pkg::ADDR_BOOT_OFF] == 8'h00 && a.addr < BOOT_BYTES)
        return !boot_valid[a.addr[7:0]];
      return !mem_valid[a.addr];
    end
    if (a.kind == mgma_pkg::KIND_WRITE && !a.force_req && !a.dma)
      return !mem_valid[mgma_pkg::ADDR_LCDC] || !mem_valid[mgma_pkg::ADDR_STAT];
    return 1'b0;
  endfunction

  // Address weighted over the memory map regions and their bounds
  function automatic logic [15:0] pick_address();
    case ($urandom_range(12))
      0:  return 16'($urandom_range(BOOT_BYTES - 1));
      1:  return 16'($urandom_range(16'h7FFF, 16'h0100));
      2:  return 16'($urandom_range(mgma_pkg::VRAM_HI, mgma_pkg::VRAM_LO));
      3:  return 16'($urandom_range(16'hBFFF, 16'hA000));
      4:  return 16'($urandom_range(mgma_pkg::WRAM_HI, mgma_pkg::WRAM_LO));
      5:  return 16'($urandom_range(16'hFDFF, 16'hE000));
      6:  return 16'($urandom_range(mgma_pkg::OAM_HI, mgma_pkg::OAM_LO));
      7:  return 16'($urandom_range(16'hFEFF, 16'hFEA0));
      8:  return 16'($urandom_range(16'hFF7F, mgma_pkg::IO_LO));
      9:  return 16'($urandom_range(mgma_pkg::HRAM_HI, mgma_pkg::HRAM_LO));
      10: begin
        case ($urandom_range(2))
          0:       return mgma_pkg::ADDR_LCDC;
          1:       return mgma_pkg::ADDR_STAT;
          default: return mgma_pkg::ADDR_BOOT_OFF;
        endcase
      end
      11: return ADDR_BOUNDS[$urandom_range(21)];
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic access_t random_access();
    access_t a;
    int      r;
    r = $urandom_range(99);
    a.kind      = (r < 45) ? mgma_pkg::KIND_READ :
                  (r < 85) ? mgma_pkg::KIND_WRITE : mgma_pkg::KIND_LOAD;
    a.wdata     = 8'($urandom);
    a.force_req = $urandom_range(99) < 15;
    a.dma       = $urandom_range(99) < 20;
    // reads mostly revisit bytes already written
    if (a.kind == mgma_pkg::KIND_READ && written_addrs.size() > 0 && $urandom_range(99) < 80)
      a.addr = written_addrs[$urandom_range(written_addrs.size() - 1)];
    else
      a.addr = pick_address();
    // keep the boot overlay switching on and off
    if (a.kind == mgma_pkg::KIND_WRITE && a.addr == mgma_pkg::ADDR_BOOT_OFF &&
        $urandom_range(1) == 0)
      a.wdata = 8'h00;
    return a;
  endfunction

  function automatic void add_row(input mgma_pkg::kind_t k, input logic [15:0] addr,
                                  input logic [7:0] d, input bit frc, input bit dma,
                                  input bit typed, input logic [7:0] rd, input bit done);
    row_t row;
    row.acc   = '{kind: k, addr: addr, wdata: d, force_req: frc, dma: dma};
    row.typed = typed;
    row.res   = '{read_data: rd, write_done: done};
    directed_rows.push_back(row);
  endfunction

  // Drive one item from a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input access_t a, input bit typed, input result_t typed_res);
    result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= a.kind;
    s_tdata  <= {6'b0, a.dma, a.force_req, a.wdata, a.addr};
    do @(posedge clk); while (!s_tready);
    res = bus_result(a);
    pending_results.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  // Receiver stalls
  always @(negedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= rx_stall_pct);
  end

  // Result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with none pending, read_data", m_tdata[7:0], 8'h00);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[7:0] !== want.read_data)
          report_mismatch("read_data", m_tdata[7:0], want.read_data);
        if (m_tdata[8] !== want.write_done)
          report_mismatch("write_done", {7'b0, m_tdata[8]}, {7'b0, want.write_done});
      end
    end
  end

  // Stimulus
  initial begin
    access_t a;
    mem_img[mgma_pkg::ADDR_BOOT_OFF]   = 8'h00;
    mem_valid[mgma_pkg::ADDR_BOOT_OFF] = 1'b1;

    // directed table: kind, address, data, force, dma, typed, read byte, done
    add_row(mgma_pkg::KIND_READ,  mgma_pkg::ADDR_BOOT_OFF, 8'h00, 0, 0, 1, 8'h00, 0);
    add_row(mgma_pkg::KIND_WRITE, mgma_pkg::ADDR_LCDC, 8'h80, 1, 0, 1, 8'h00, 1);  // LCD on
    add_row(mgma_pkg::KIND_WRITE, mgma_pkg::ADDR_STAT, 8'h03, 1, 0, 1, 8'h00, 1);  // xfer
    add_row(mgma_pkg::KIND_WRITE, 16'h8000, 8'h5A, 0, 0, 1, 8'h00, 0);  // VRAM locked
    add_row(mgma_pkg::KIND_WRITE, 16'h9FFF, 8'hA5, 1, 0, 1, 8'h00, 1);  // forced past lock
    add_row(mgma_pkg::KIND_WRITE, 16'hFE00, 8'h11, 0, 0, 1, 8'h00, 0);  // OAM locked
    add_row(mgma_pkg::KIND_WRITE, mgma_pkg::ADDR_STAT, 8'h01, 0, 0, 1, 8'h00, 1);  // vblank
    add_row(mgma_pkg::KIND_WRITE, 16'hFE9F, 8'h22, 0, 0, 1, 8'h00, 1);  // OAM open
    add_row(mgma_pkg::KIND_WRITE, 16'hFEA0, 8'h33, 0, 0, 1, 8'h00, 0);  // unusable area
    add_row(mgma_pkg::KIND_WRITE, 16'hC000, 8'h00, 0, 0, 1, 8'h00, 1);
    add_row(mgma_pkg::KIND_WRITE, 16'hFF80, 8'h77, 0, 1, 1, 8'h00, 1);  // high RAM, DMA
    add_row(mgma_pkg::KIND_WRITE, 16'hC001, 8'h44, 0, 1, 1, 8'h00, 0);  // work RAM, DMA
    add_row(mgma_pkg::KIND_WRITE, mgma_pkg::ADDR_IE, 8'h1F, 0, 0, 1, 8'h00, 1);
    add_row(mgma_pkg::KIND_WRITE, 16'hFF7F, 8'h55, 0, 0, 1, 8'h00, 0);  // gap before HRAM
    add_row(mgma_pkg::KIND_WRITE, 16'h0000, 8'h3C, 1, 1, 1, 8'h00, 1);  // forced ROM write
    add_row(mgma_pkg::KIND_WRITE, 16'h00FF, 8'h6B, 1, 0, 1, 8'h00, 1);
    add_row(mgma_pkg::KIND_LOAD,  16'h1200, 8'hC3, 0, 0, 1, 8'h00, 1);  // index from low byte
    add_row(mgma_pkg::KIND_LOAD,  16'hFFFF, 8'h7E, 0, 0, 1, 8'h00, 1);
    add_row(mgma_pkg::KIND_READ,  16'h0000, 8'h00, 0, 0, 1, 8'hC3, 0);  // overlay
    add_row(mgma_pkg::KIND_READ,  16'h00FF, 8'h00, 1, 1, 1, 8'h7E, 0);  // forced overlay
    add_row(mgma_pkg::KIND_READ,  16'h0000, 8'h00, 0, 1, 1, 8'hFF, 0);  // DMA blank
    add_row(mgma_pkg::KIND_READ,  16'hFF80, 8'h00, 0, 1, 1, 8'h77, 0);
    add_row(mgma_pkg::KIND_READ,  16'h9FFF, 8'h00, 0, 0, 0, 8'h00, 0);
    add_row(mgma_pkg::KIND_WRITE, mgma_pkg::ADDR_BOOT_OFF, 8'h01, 0, 0, 1, 8'h00, 1);  // off
    add_row(mgma_pkg::KIND_READ,  16'h0000, 8'h00, 0, 0, 1, 8'h3C, 0);
    add_row(mgma_pkg::KIND_WRITE, mgma_pkg::ADDR_LCDC, 8'h00, 0, 0, 1, 8'h00, 1);  // LCD off
    add_row(mgma_pkg::KIND_WRITE, mgma_pkg::ADDR_STAT, 8'h03, 0, 0, 1, 8'h00, 1);
    add_row(mgma_pkg::KIND_WRITE, 16'h8000, 8'h5A, 0, 0, 1, 8'h00, 1);  // VRAM open, LCD off

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].acc, directed_rows[i].typed, directed_rows[i].res);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // stretch with no idling on either side
      if (i == 300) begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      if (i == 450) begin
        tx_idle_pct  = 13;
        rx_stall_pct = 13;
      end
      // drain all results before going on
      if (i == 600) begin
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
      end
      do a = random_access(); while (touches_unwritten(a));
      send_item(a, 1'b0, '0);
    end

    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    repeat (4) @(negedge clk);

    $display("Run: %0d reads (%0d via boot overlay, %0d blanked by DMA), %0d writes",
             n_reads, n_boot_reads, n_dma_blank, n_writes);
    $display("     %0d stores accepted, %0d boot loads, %0d results checked, %0d errors",
             n_stored, n_loads, n_results, error_count);
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mgma_pkg.sv
rtl/mgma_ram.sv
rtl/mgma_gate.sv
rtl/mode_gated_memory_access_unit.sv
verif/testbench.sv
